// ----- src/clock_time_entry_controller_unit_assert.svh -----
// Assertion macros used by the controller RTL (ctec_back)
`ifndef CLOCK_TIME_ENTRY_CONTROLLER_UNIT_ASSERT_SVH
`define CLOCK_TIME_ENTRY_CONTROLLER_UNIT_ASSERT_SVH

// check a condition on every rising clock edge outside reset
`define CTEC_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// check a consequence in the cycle after a trigger
`define CTEC_ASSERT_NEXT(name, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/ctec_pkg.sv -----
// Shared types, codes and constants of the time entry controller
`default_nettype none

package ctec_pkg;

    localparam int unsigned CTEC_QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_ZERO      = 8'h30;
    localparam logic [7:0] ASCII_NINE      = 8'h39;
    localparam logic [7:0] KEY_NEWLINE     = 8'h0A;
    localparam logic [7:0] KEY_LOWER_R     = 8'h72;

    localparam logic [7:0] RESET_KEY_DEFAULT      = 8'd70;
    localparam logic [7:0] SET_CANCEL_KEY_DEFAULT = 8'd69;

    localparam logic [1:0] CFG_RESET_KEY      = 2'd0;
    localparam logic [1:0] CFG_SET_CANCEL_KEY = 2'd1;
    localparam logic [1:0] CFG_TWELVE_HOUR    = 2'd2;

    typedef enum logic [2:0] {
        ACT_NONE    = 3'd0,
        ACT_RESET   = 3'd1,
        ACT_START   = 3'd2,
        ACT_DIGIT   = 3'd3,
        ACT_CANCEL  = 3'd4,
        ACT_SET     = 3'd5,
        ACT_UNKNOWN = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        KIND_RESET,
        KIND_SET_CANCEL,
        KIND_DIGIT,
        KIND_IGNORE,
        KIND_UNKNOWN
    } key_kind_t;

    typedef struct packed {
        key_kind_t  kind;
        logic [3:0] digit;
        logic       twelve_hour;
    } key_item_t;

endpackage

`default_nettype wire

// ----- src/clock_time_entry_controller_unit.sv -----
// Top level of the time entry controller: front, queue and back
//
//  port group   | direction | transfer
//  -------------+-----------+------------------------------------------
//  cfg_*        | in        | write when cfg_we is high, no wait
//  key_code     | in        | in_valid & in_ready
//  result ports | out       | out_valid & out_ready
//
//  One key per cycle while the queue has room; a key is queued at the
//  accepting edge and its result is registered on pop. The back end retires
//  one queued key per cycle into a single result register when free or read.
//  in_ready drops only when the queue is full, which needs out_ready low.
//  Reset clears state to standby with default key codes and 24-hour limits.
`default_nettype none

module clock_time_entry_controller_unit
#(
    parameter int unsigned QUEUE_DEPTH = ctec_pkg::CTEC_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  key_code,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       action,
    output logic             clock_reset_pulse,
    output logic [11:0]      new_time_hhmm,
    output logic [11:0]      partial_entry,
    output logic [1:0]       digits_entered,
    output logic             in_entry_mode
);
    import ctec_pkg::*;

    logic      push;
    key_item_t push_item;
    logic      queue_full;
    logic      q_valid;
    key_item_t q_item;
    logic      pop;

    ctec_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .key_code   (key_code),
        .queue_full (queue_full),
        .in_ready   (in_ready),
        .push       (push),
        .push_item  (push_item)
    );

    ctec_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .full      (queue_full),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    ctec_back u_back
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .action            (action),
        .clock_reset_pulse (clock_reset_pulse),
        .new_time_hhmm     (new_time_hhmm),
        .partial_entry     (partial_entry),
        .digits_entered    (digits_entered),
        .in_entry_mode     (in_entry_mode)
    );

endmodule

`default_nettype wire

// ----- src/ctec_front.sv -----
// Front end: configuration registers and key classification
`default_nettype none

module ctec_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              in_valid,
    input  wire logic [7:0]        key_code,
    input  wire logic              queue_full,
    output logic                   in_ready,
    output logic                   push,
    output ctec_pkg::key_item_t    push_item
);
    import ctec_pkg::*;

    logic [7:0] reset_key_reg;
    logic [7:0] set_cancel_key_reg;
    logic       twelve_hour_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_key_reg      <= RESET_KEY_DEFAULT;
            set_cancel_key_reg <= SET_CANCEL_KEY_DEFAULT;
            twelve_hour_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RESET_KEY:      reset_key_reg      <= cfg_data;
                CFG_SET_CANCEL_KEY: set_cancel_key_reg <= cfg_data;
                CFG_TWELVE_HOUR:    twelve_hour_reg    <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    logic [7:0] digit_offset;

    always_comb
    begin
        digit_offset          = key_code - ASCII_ZERO;
        push_item.digit       = digit_offset[3:0];
        push_item.twelve_hour = twelve_hour_reg;
        if (key_code == reset_key_reg)
            push_item.kind = KIND_RESET;
        else if (key_code == set_cancel_key_reg)
            push_item.kind = KIND_SET_CANCEL;
        else if (key_code inside {[ASCII_ZERO:ASCII_NINE]})
            push_item.kind = KIND_DIGIT;
        else if (key_code inside {KEY_NEWLINE, KEY_LOWER_R})
            push_item.kind = KIND_IGNORE;
        else
            push_item.kind = KIND_UNKNOWN;
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

endmodule

`default_nettype wire

// ----- src/ctec_queue.sv -----
// Small queue of classified keys between front and back
`default_nettype none

module ctec_queue
#(
    parameter int unsigned DEPTH = ctec_pkg::CTEC_QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ctec_pkg::key_item_t push_item,
    input  wire logic                pop,
    output logic                     full,
    output logic                     q_valid,
    output ctec_pkg::key_item_t      q_item
);
    import ctec_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    key_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

endmodule

`default_nettype wire

// ----- src/ctec_back.sv -----
// Back end: entry state machine, digit clamps and result register
`default_nettype none
`include "clock_time_entry_controller_unit_assert.svh"

module ctec_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_valid,
    input  wire ctec_pkg::key_item_t q_item,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [2:0]               action,
    output logic                     clock_reset_pulse,
    output logic [11:0]              new_time_hhmm,
    output logic [11:0]              partial_entry,
    output logic [1:0]               digits_entered,
    output logic                     in_entry_mode
);
    import ctec_pkg::*;

    logic        entry_mode_reg,    entry_mode_next;
    logic [11:0] entry_value_reg,   entry_value_next;
    logic [1:0]  digit_count_reg,   digit_count_next;
    logic        reset_pending_reg, reset_pending_next;
    logic        out_valid_reg,     out_valid_next;

    action_t     action_reg,   action_next;
    logic        pulse_reg,    pulse_next;
    logic [11:0] new_time_reg, new_time_next;

    logic [3:0]  digit;
    logic [11:0] value_x10;
    logic [11:0] value_acc;

    assign pop = q_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        digit = q_item.digit;
        case (digit_count_reg)
            2'd0:
            begin
                if (q_item.twelve_hour)
                    digit = (digit > 4'd1) ? 4'd1 : digit;
                else
                    digit = (digit > 4'd2) ? 4'd2 : digit;
            end
            2'd1:
            begin
                if (q_item.twelve_hour)
                begin
                    if (entry_value_reg == 12'd0)
                        digit = (digit < 4'd1) ? 4'd1 : digit;
                    else
                        digit = (digit > 4'd2) ? 4'd2 : digit;
                end
                else if (entry_value_reg == 12'd2)
                    digit = (digit > 4'd3) ? 4'd3 : digit;
            end
            2'd2:    digit = (digit > 4'd5) ? 4'd5 : digit;
            default: ;
        endcase
        value_x10 = {entry_value_reg[8:0], 3'b000} + {entry_value_reg[10:0], 1'b0};
        value_acc = value_x10 + {8'd0, digit};
    end

    always_comb
    begin
        entry_mode_next    = entry_mode_reg;
        entry_value_next   = entry_value_reg;
        digit_count_next   = digit_count_reg;
        reset_pending_next = reset_pending_reg;
        action_next        = ACT_NONE;
        pulse_next         = 1'b0;
        new_time_next      = 12'd0;
        case (q_item.kind)
            KIND_RESET:
            begin
                if (entry_mode_reg)
                    reset_pending_next = 1'b1;
                else
                begin
                    action_next        = ACT_RESET;
                    pulse_next         = 1'b1;
                    reset_pending_next = 1'b0;
                end
            end
            KIND_SET_CANCEL:
            begin
                if (entry_mode_reg)
                begin
                    action_next        = ACT_CANCEL;
                    entry_mode_next    = 1'b0;
                    entry_value_next   = 12'd0;
                    digit_count_next   = 2'd0;
                    pulse_next         = reset_pending_reg;
                    reset_pending_next = 1'b0;
                end
                else
                begin
                    action_next     = ACT_START;
                    entry_mode_next = 1'b1;
                end
            end
            KIND_DIGIT:
            begin
                if (entry_mode_reg)
                begin
                    if (digit_count_reg == 2'd3)
                    begin
                        action_next        = ACT_SET;
                        new_time_next      = value_acc;
                        entry_mode_next    = 1'b0;
                        entry_value_next   = 12'd0;
                        digit_count_next   = 2'd0;
                        pulse_next         = reset_pending_reg;
                        reset_pending_next = 1'b0;
                    end
                    else
                    begin
                        action_next      = ACT_DIGIT;
                        entry_value_next = value_acc;
                        digit_count_next = digit_count_reg + 2'd1;
                    end
                end
            end
            KIND_IGNORE:  ;
            KIND_UNKNOWN: action_next = ACT_UNKNOWN;
            default:      ;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_mode_reg    <= 1'b0;
            entry_value_reg   <= 12'd0;
            digit_count_reg   <= 2'd0;
            reset_pending_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                entry_mode_reg    <= entry_mode_next;
                entry_value_reg   <= entry_value_next;
                digit_count_reg   <= digit_count_next;
                reset_pending_reg <= reset_pending_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            action_reg   <= action_next;
            pulse_reg    <= pulse_next;
            new_time_reg <= new_time_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign action            = action_reg;
    assign clock_reset_pulse = pulse_reg;
    assign new_time_hhmm     = new_time_reg;
    assign partial_entry     = entry_value_reg;
    assign digits_entered    = digit_count_reg;
    assign in_entry_mode     = entry_mode_reg;

    `CTEC_ASSERT(a_count_needs_entry, (digit_count_reg == 2'd0) || entry_mode_reg, "digits held outside entry mode")
    `CTEC_ASSERT(a_pending_needs_entry, !reset_pending_reg || entry_mode_reg, "reset pending in standby")
    `CTEC_ASSERT(a_pulse_action, !(out_valid_reg && pulse_reg) || action_reg == ACT_RESET || action_reg == ACT_CANCEL || action_reg == ACT_SET, "clock reset pulse with wrong action")
    `CTEC_ASSERT_NEXT(a_set_leaves_entry, pop && action_next == ACT_SET, !entry_mode_reg && digit_count_reg == 2'd0 && entry_value_reg == 12'd0, "time set left entry state behind")

endmodule

`default_nettype wire

// ----- test/clock_time_entry_controller_unit_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the time entry controller: directed key table, random key sessions, scoreboard

module clock_time_entry_controller_unit_tb;

    import ctec_pkg::*;

    typedef struct packed {
        action_t     action;
        logic        pulse;
        logic [11:0] new_time;
        logic [11:0] partial;
        logic [1:0]  digits;
        logic        entry;
    } key_result_t;

    typedef struct packed {
        logic [7:0]  key;
        logic        typed;
        key_result_t want;
    } key_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  key_code;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  action;
    logic        clock_reset_pulse;
    logic [11:0] new_time_hhmm;
    logic [11:0] partial_entry;
    logic [1:0]  digits_entered;
    logic        in_entry_mode;

    key_result_t expected_q[$];
    int          mismatches = 0;
    int          burst_left = 0;

    logic [7:0]  cfg_reset_code;
    logic [7:0]  cfg_set_code;
    logic        cfg_twelve;
    logic        in_entry;
    logic [11:0] typed_value;
    logic [1:0]  typed_count;
    logic        deferred_reset;

    key_row_t    directed_keys [23];

    int          stall_mode;
    int          stall_left;

    clock_time_entry_controller_unit u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .key_code          (key_code),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .action            (action),
        .clock_reset_pulse (clock_reset_pulse),
        .new_time_hhmm     (new_time_hhmm),
        .partial_entry     (partial_entry),
        .digits_entered    (digits_entered),
        .in_entry_mode     (in_entry_mode)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic key_result_t outcome(action_t a, logic p, int nt, int pe, int dg,
                                            logic em);
        key_result_t r;
        r.action   = a;
        r.pulse    = p;
        r.new_time = 12'(nt);
        r.partial  = 12'(pe);
        r.digits   = 2'(dg);
        r.entry    = em;
        return r;
    endfunction

    function automatic key_result_t predict_key(input logic [7:0] k);
        key_result_t r;
        logic [3:0]  d;
        r = '0;
        r.action = ACT_NONE;
        if (k == cfg_reset_code)
        begin
            if (in_entry)
                deferred_reset = 1'b1;
            else
            begin
                r.action = ACT_RESET;
                r.pulse = 1'b1;
                deferred_reset = 1'b0;
            end
        end
        else if (k == cfg_set_code)
        begin
            if (in_entry)
            begin
                r.action = ACT_CANCEL;
                in_entry = 1'b0;
                typed_value = '0;
                typed_count = '0;
                r.pulse = deferred_reset;
                deferred_reset = 1'b0;
            end
            else
            begin
                r.action = ACT_START;
                in_entry = 1'b1;
            end
        end
        else if (k >= ASCII_ZERO && k <= ASCII_NINE)
        begin
            if (in_entry)
            begin
                d = 4'(k - ASCII_ZERO);
                case (typed_count)
                    2'd0:
                    begin
                        if (cfg_twelve && d > 4'd1)
                            d = 4'd1;
                        else if (!cfg_twelve && d > 4'd2)
                            d = 4'd2;
                    end
                    2'd1:
                    begin
                        if (cfg_twelve)
                        begin
                            if (typed_value == 12'd0)
                            begin
                                if (d < 4'd1)
                                    d = 4'd1;
                            end
                            else if (d > 4'd2)
                                d = 4'd2;
                        end
                        else if (typed_value == 12'd2 && d > 4'd3)
                            d = 4'd3;
                    end
                    2'd2:
                    begin
                        if (d > 4'd5)
                            d = 4'd5;
                    end
                    default:
                    begin
                    end
                endcase
                typed_value = 12'(typed_value * 12'd10 + 12'(d));
                if (typed_count == 2'd3)
                begin
                    r.action = ACT_SET;
                    r.new_time = typed_value;
                    in_entry = 1'b0;
                    typed_value = '0;
                    typed_count = '0;
                    r.pulse = deferred_reset;
                    deferred_reset = 1'b0;
                end
                else
                begin
                    r.action = ACT_DIGIT;
                    typed_count = typed_count + 2'd1;
                end
            end
        end
        else if (k != KEY_NEWLINE && k != KEY_LOWER_R)
            r.action = ACT_UNKNOWN;
        r.partial = typed_value;
        r.digits  = typed_count;
        r.entry   = in_entry;
        return r;
    endfunction

    // hold valid across a burst, drop it only for a real gap
    task automatic send_key(input logic [7:0] k, input key_result_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        expected_q.push_back(want);
        in_valid <= 1'b1;
        key_code <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_RESET_KEY:      cfg_reset_code = data;
            CFG_SET_CANCEL_KEY: cfg_set_code = data;
            CFG_TWELVE_HOUR:    cfg_twelve = data[0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic run_phase(input logic [7:0] rk, input logic [7:0] sk, input logic tw,
                             input int target);
        int          hits;
        int          n;
        int          drain_at;
        int          r;
        logic [7:0]  k;
        key_result_t want;
        drain_results();
        write_reg(CFG_RESET_KEY, rk);
        write_reg(CFG_SET_CANCEL_KEY, sk);
        write_reg(CFG_TWELVE_HOUR, {7'($urandom_range(0, 127)), tw});
        cfg_we <= 1'b0;
        @(posedge clk);
        hits = 0;
        n = 0;
        drain_at = $urandom_range(10, 80);
        while (hits < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
                k = cfg_set_code;
            else if (r < 17)
                k = cfg_reset_code;
            else if (r < 72)
                k = 8'(ASCII_ZERO + $urandom_range(0, 9));
            else if (r < 77)
                k = ($urandom_range(0, 1) == 0) ? KEY_NEWLINE : KEY_LOWER_R;
            else
                k = 8'($urandom_range(0, 255));
            want = predict_key(k);
            send_key(k, want);
            if (want.action != ACT_NONE)
                hits++;
            n++;
            if (n == drain_at)
                drain_results();
        end
    endtask

    initial
    begin
        int          i;
        key_result_t want;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        key_code  <= '0;
        cfg_reset_code = RESET_KEY_DEFAULT;
        cfg_set_code   = SET_CANCEL_KEY_DEFAULT;
        cfg_twelve     = 1'b0;
        in_entry       = 1'b0;
        typed_value    = '0;
        typed_count    = '0;
        deferred_reset = 1'b0;

        directed_keys = '{
            '{8'h46, 1'b1, outcome(ACT_RESET,   1'b1, 0,    0,   0, 1'b0)},
            '{8'h35, 1'b1, outcome(ACT_NONE,    1'b0, 0,    0,   0, 1'b0)},
            '{8'h0A, 1'b1, outcome(ACT_NONE,    1'b0, 0,    0,   0, 1'b0)},
            '{8'h72, 1'b1, outcome(ACT_NONE,    1'b0, 0,    0,   0, 1'b0)},
            '{8'h00, 1'b1, outcome(ACT_UNKNOWN, 1'b0, 0,    0,   0, 1'b0)},
            '{8'hFF, 1'b1, outcome(ACT_UNKNOWN, 1'b0, 0,    0,   0, 1'b0)},
            '{8'h45, 1'b1, outcome(ACT_START,   1'b0, 0,    0,   0, 1'b1)},
            '{8'h39, 1'b1, outcome(ACT_DIGIT,   1'b0, 0,    2,   1, 1'b1)},
            '{8'h39, 1'b1, outcome(ACT_DIGIT,   1'b0, 0,    23,  2, 1'b1)},
            '{8'h46, 1'b1, outcome(ACT_NONE,    1'b0, 0,    23,  2, 1'b1)},
            '{8'h46, 1'b1, outcome(ACT_NONE,    1'b0, 0,    23,  2, 1'b1)},
            '{8'h39, 1'b1, outcome(ACT_DIGIT,   1'b0, 0,    235, 3, 1'b1)},
            '{8'h78, 1'b1, outcome(ACT_UNKNOWN, 1'b0, 0,    235, 3, 1'b1)},
            '{8'h39, 1'b1, outcome(ACT_SET,     1'b1, 2359, 0,   0, 1'b0)},
            '{8'h45, 1'b0, '0},
            '{8'h31, 1'b0, '0},
            '{8'h46, 1'b0, '0},
            '{8'h45, 1'b1, outcome(ACT_CANCEL,  1'b1, 0,    0,   0, 1'b0)},
            '{8'h45, 1'b0, '0},
            '{8'h30, 1'b0, '0},
            '{8'h30, 1'b0, '0},
            '{8'h30, 1'b0, '0},
            '{8'h30, 1'b1, outcome(ACT_SET,     1'b0, 0,    0,   0, 1'b0)}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < 23; i++)
        begin
            want = predict_key(directed_keys[i].key);
            if (directed_keys[i].typed)
                want = directed_keys[i].want;
            send_key(directed_keys[i].key, want);
        end

        run_phase(RESET_KEY_DEFAULT, SET_CANCEL_KEY_DEFAULT, 1'b1, 65);
        run_phase(8'h00, 8'hFF, 1'b0, 65);
        run_phase(8'hFF, 8'h00, 1'b1, 65);
        run_phase(8'h33, KEY_NEWLINE, 1'b1, 65);
        run_phase(KEY_LOWER_R, ASCII_ZERO, 1'b0, 65);
        run_phase(8'h41, 8'h41, 1'b1, 20);
        run_phase(RESET_KEY_DEFAULT, SET_CANCEL_KEY_DEFAULT, 1'b0, 65);

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // stall the result side in modes that change when a random countdown runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode <= 0;
            stall_left <= 0;
        end
        else
        begin
            if (stall_left == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(16, 120);
            end
            else
                stall_left <= stall_left - 1;
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= 1'($urandom_range(0, 1));
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= stall_left[3];
            endcase
        end
    end

    always @(posedge clk)
    begin : check_results
        key_result_t want;
        key_result_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got = {action, clock_reset_pulse, new_time_hhmm, partial_entry, digits_entered,
                   in_entry_mode};
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: %0d/%0d/%0d/%0d/%0d/%0d",
                             got.action, got.pulse, got.new_time, got.partial, got.digits,
                             got.entry);
            end
            else
            begin
                want = expected_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display(
                            "mismatch exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                            want.action, want.pulse, want.new_time, want.partial,
                            want.digits, want.entry, got.action, got.pulse,
                            got.new_time, got.partial, got.digits, got.entry);
                end
            end
        end
    end

endmodule

// ----- filelist.f -----
+incdir+src
src/ctec_pkg.sv
src/ctec_front.sv
src/ctec_queue.sv
src/ctec_back.sv
src/clock_time_entry_controller_unit.sv
test/clock_time_entry_controller_unit_tb.sv
